// ===== hw/rtl/thrp_pkg.sv =====
package thrp_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_AT    = 8'h40;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_ZERO  = 8'd48;

   localparam logic KIND_DATA    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef enum logic [3:0] {
      ST_OK        = 4'd0,
      ST_NO_AT     = 4'd1,
      ST_TRUNCATED = 4'd2,
      ST_BAD_SRC   = 4'd3,
      ST_ODD_LEN   = 4'd4,
      ST_TOO_LONG  = 4'd5,
      ST_BAD_DATA  = 4'd6,
      ST_BAD_CK    = 4'd7,
      ST_MISMATCH  = 4'd8
   } thrp_status_type;

   typedef enum logic [3:0] {
      PH_AT     = 4'd0,
      PH_TIME   = 4'd1,
      PH_GROUP  = 4'd2,
      PH_SRC_HI = 4'd3,
      PH_SRC_LO = 4'd4,
      PH_SEP    = 4'd5,
      PH_DATA   = 4'd6,
      PH_CK_HI  = 4'd7,
      PH_CK_LO  = 4'd8,
      PH_TAIL   = 4'd9,
      PH_SKIP   = 4'd10
   } thrp_phase_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       line_end;
   } thrp_req_type;

   typedef struct packed {
      logic            kind;
      logic [7:0]      data_byte;
      logic [7:0]      byte_index;
      logic [31:0]     timestamp;
      logic [31:0]     group_number;
      logic [7:0]      source_address;
      logic [7:0]      payload_length;
      thrp_status_type status;
   } thrp_rsp_type;

   // Classified character passed from front to back
   typedef struct packed {
      logic [7:0] char_code;
      logic       is_end;
      logic       is_at;
      logic       is_star;
      logic       is_comma;
      logic       hex_ok;
      logic [3:0] hex_nib;
   } thrp_tok_type;

   typedef struct packed {
      logic full;
      logic empty;
   } thrp_qstat_type;

   typedef struct packed {
      logic no_at;
      logic bad_src;
      logic too_long;
      logic bad_data;
      logic bad_ck;
   } thrp_err_type;

endpackage

// ===== hw/rtl/thrp_front.sv =====
module thrp_front (
   input  logic                  req_valid,
   input  thrp_pkg::thrp_req_type req_payload,
   input  thrp_pkg::thrp_qstat_type qstat,
   output logic                  req_stall,
   output logic                  push,
   output thrp_pkg::thrp_tok_type push_tok
);
   import thrp_pkg::*;

   logic [7:0] c;

   assign c         = req_payload.char_code;
   assign req_stall = qstat.full;
   assign push      = req_valid && !qstat.full;

   always_comb begin
      push_tok           = '0;
      push_tok.char_code = c;
      push_tok.is_end    = req_payload.line_end || (c == CHAR_NUL);
      push_tok.is_at     = (c == CHAR_AT);
      push_tok.is_star   = (c == CHAR_STAR);
      push_tok.is_comma  = (c == CHAR_COMMA);
      // hex digit of either case
      if (c >= 8'h30 && c <= 8'h39) begin
         push_tok.hex_ok  = 1'b1;
         push_tok.hex_nib = c[3:0];
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         push_tok.hex_ok  = 1'b1;
         push_tok.hex_nib = c[3:0] + 4'd9;
      end else begin
         push_tok.hex_ok  = 1'b0;
         push_tok.hex_nib = 4'h0;
      end
   end

endmodule

// ===== hw/rtl/thrp_queue.sv =====
module thrp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  thrp_pkg::thrp_tok_type  push_tok,
   input  logic                    pop,
   output thrp_pkg::thrp_tok_type  head_tok,
   output thrp_pkg::thrp_qstat_type qstat
);
   import thrp_pkg::*;

   thrp_tok_type      mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign qstat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign head_tok    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_tok;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      qstat.full |-> !push)
      else $error("push into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      qstat.empty |-> !pop)
      else $error("pop from empty queue");

endmodule

// ===== hw/rtl/thrp_back.sv =====
module thrp_back #(
   parameter int MAX_DATA_BYTES = 223
) (
   input  logic                     clock,
   input  logic                     reset,
   input  thrp_pkg::thrp_tok_type   head_tok,
   input  thrp_pkg::thrp_qstat_type qstat,
   output logic                     pop,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output thrp_pkg::thrp_rsp_type   rsp_payload
);
   import thrp_pkg::*;

   thrp_phase_type phase_ff, phase_in;
   logic [31:0]    time_ff, time_in;
   logic [31:0]    group_ff, group_in;
   logic [7:0]     source_ff, source_in;
   logic [7:0]     xor_ff, xor_in;
   logic [3:0]     high_nib_ff, high_nib_in;
   logic           half_pair_ff, half_pair_in;
   logic [7:0]     pair_count_ff, pair_count_in;
   logic [7:0]     seen_ck_ff, seen_ck_in;
   thrp_err_type   err_ff, err_in;
   logic           sum_closed_ff, sum_closed_in;
   logic           rsp_valid_ff, rsp_valid_in;
   thrp_rsp_type   rsp_ff, rsp_in;
   logic           emit;
   logic [3:0]     nib;
   thrp_status_type line_status;

   function automatic logic [31:0] dec_step(input logic [31:0] acc, input logic [7:0] c);
      logic [31:0] times10;
      times10  = {acc[28:0], 3'b000} + {acc[30:0], 1'b0};
      dec_step = times10 + {24'h0, c} - {24'h0, CHAR_ZERO};
   endfunction

   // take the next request whenever the output register is free or draining
   assign pop         = !qstat.empty && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign nib         = head_tok.hex_ok ? head_tok.hex_nib : 4'h0;

   // summary status; errors are ranked in a fixed order, not by which came first
   always_comb begin
      priority if (err_ff.no_at || phase_ff == PH_AT) begin
         line_status = ST_NO_AT;
      end else if (phase_ff == PH_TIME || phase_ff == PH_GROUP || phase_ff == PH_SRC_HI ||
                   phase_ff == PH_SRC_LO || phase_ff == PH_SEP) begin
         line_status = ST_TRUNCATED;
      end else if (err_ff.bad_src) begin
         line_status = ST_BAD_SRC;
      end else if (phase_ff == PH_DATA && half_pair_ff) begin
         line_status = ST_ODD_LEN;
      end else if (err_ff.too_long) begin
         line_status = ST_TOO_LONG;
      end else if (err_ff.bad_data) begin
         line_status = ST_BAD_DATA;
      end else if (phase_ff == PH_DATA || phase_ff == PH_CK_HI || phase_ff == PH_CK_LO) begin
         line_status = ST_TRUNCATED;
      end else if (err_ff.bad_ck) begin
         line_status = ST_BAD_CK;
      end else if (seen_ck_ff != xor_ff) begin
         line_status = ST_MISMATCH;
      end else begin
         line_status = ST_OK;
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (pop) begin
         if (head_tok.is_end) begin
            phase_in = PH_AT;
         end else begin
            unique case (phase_ff)
               PH_AT:     phase_in = head_tok.is_at ? PH_TIME : PH_SKIP;
               PH_TIME:   phase_in = head_tok.is_comma ? PH_GROUP : PH_TIME;
               PH_GROUP:  phase_in = head_tok.is_comma ? PH_SRC_HI : PH_GROUP;
               PH_SRC_HI: phase_in = PH_SRC_LO;
               PH_SRC_LO: phase_in = PH_SEP;
               PH_SEP:    phase_in = PH_DATA;
               PH_DATA:   phase_in = head_tok.is_star ? PH_CK_HI : PH_DATA;
               PH_CK_HI:  phase_in = PH_CK_LO;
               PH_CK_LO:  phase_in = PH_TAIL;
               PH_TAIL:   phase_in = PH_TAIL;
               PH_SKIP:   phase_in = PH_SKIP;
               default:   phase_in = PH_AT;
            endcase
         end
      end
   end

   // field updates and result
   always_comb begin
      time_in       = time_ff;
      group_in      = group_ff;
      source_in     = source_ff;
      xor_in        = xor_ff;
      high_nib_in   = high_nib_ff;
      half_pair_in  = half_pair_ff;
      pair_count_in = pair_count_ff;
      seen_ck_in    = seen_ck_ff;
      err_in        = err_ff;
      sum_closed_in = sum_closed_ff;
      emit          = 1'b0;
      rsp_in        = rsp_ff;

      if (pop) begin
         if (head_tok.is_end) begin
            emit                  = 1'b1;
            rsp_in.kind           = KIND_SUMMARY;
            rsp_in.data_byte      = 8'h00;
            rsp_in.byte_index     = 8'h00;
            rsp_in.timestamp      = time_ff;
            rsp_in.group_number   = group_ff;
            rsp_in.source_address = source_ff;
            rsp_in.payload_length = pair_count_ff;
            rsp_in.status         = line_status;
            // back to the start of a line
            time_in       = '0;
            group_in      = '0;
            source_in     = '0;
            xor_in        = '0;
            high_nib_in   = '0;
            half_pair_in  = 1'b0;
            pair_count_in = '0;
            seen_ck_in    = '0;
            err_in        = '0;
            sum_closed_in = 1'b0;
         end else begin
            if (phase_ff != PH_AT && phase_ff != PH_SKIP && !sum_closed_ff) begin
               if (head_tok.is_star) begin
                  sum_closed_in = 1'b1;
               end else begin
                  xor_in = xor_ff ^ head_tok.char_code;
               end
            end
            unique case (phase_ff)
               PH_AT: begin
                  if (!head_tok.is_at) begin
                     err_in.no_at = 1'b1;
                  end
               end
               PH_TIME: begin
                  if (!head_tok.is_comma) begin
                     time_in = dec_step(time_ff, head_tok.char_code);
                  end
               end
               PH_GROUP: begin
                  if (!head_tok.is_comma) begin
                     group_in = dec_step(group_ff, head_tok.char_code);
                  end
               end
               PH_SRC_HI, PH_SRC_LO: begin
                  if (!head_tok.hex_ok) begin
                     err_in.bad_src = 1'b1;
                  end
                  source_in = {source_ff[3:0], nib};
               end
               PH_DATA: begin
                  if (!head_tok.is_star) begin
                     if (!head_tok.hex_ok) begin
                        err_in.bad_data = 1'b1;
                     end
                     if (!half_pair_ff) begin
                        high_nib_in  = nib;
                        half_pair_in = 1'b1;
                     end else begin
                        half_pair_in = 1'b0;
                        if (pair_count_ff >= 8'(MAX_DATA_BYTES)) begin
                           err_in.too_long = 1'b1;
                        end else begin
                           if (!err_in.bad_data) begin
                              emit                  = 1'b1;
                              rsp_in.kind           = KIND_DATA;
                              rsp_in.data_byte      = {high_nib_ff, nib};
                              rsp_in.byte_index     = pair_count_ff;
                              rsp_in.timestamp      = time_ff;
                              rsp_in.group_number   = group_ff;
                              rsp_in.source_address = source_ff;
                              rsp_in.payload_length = 8'h00;
                              rsp_in.status         = ST_OK;
                           end
                           pair_count_in = pair_count_ff + 1'b1;
                        end
                     end
                  end
               end
               PH_CK_HI, PH_CK_LO: begin
                  if (!head_tok.hex_ok) begin
                     err_in.bad_ck = 1'b1;
                  end
                  seen_ck_in = {seen_ck_ff[3:0], nib};
               end
               default: begin
               end
            endcase
         end
      end

      // hold the result until taken
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_AT;
         time_ff       <= '0;
         group_ff      <= '0;
         source_ff     <= '0;
         xor_ff        <= '0;
         high_nib_ff   <= '0;
         half_pair_ff  <= 1'b0;
         pair_count_ff <= '0;
         seen_ck_ff    <= '0;
         err_ff        <= '0;
         sum_closed_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         time_ff       <= time_in;
         group_ff      <= group_in;
         source_ff     <= source_in;
         xor_ff        <= xor_in;
         high_nib_ff   <= high_nib_in;
         half_pair_ff  <= half_pair_in;
         pair_count_ff <= pair_count_in;
         seen_ck_ff    <= seen_ck_in;
         err_ff        <= err_in;
         sum_closed_ff <= sum_closed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      pair_count_ff <= 8'(MAX_DATA_BYTES))
      else $error("pair count past maximum");

   a_line_restart: assert property (@(posedge clock) disable iff (reset)
      pop && head_tok.is_end |=> phase_ff == PH_AT && pair_count_ff == '0 && rsp_valid_ff &&
         rsp_ff.kind == KIND_SUMMARY)
      else $error("line end did not restart the parser");

   a_data_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.kind == KIND_DATA |-> rsp_ff.status == ST_OK &&
         rsp_ff.payload_length == '0 && !err_ff.bad_data)
      else $error("data byte carries status or follows bad data");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !pop)
      else $error("request taken while result stalled");

endmodule

// ===== hw/rtl/timestamped_hex_record_parser_top.sv =====
// channel | direction | handshake            | payload
// req     | in        | req_valid, req_stall | thrp_req_type: char_code, line_end
// rsp     | out       | rsp_valid, rsp_stall | thrp_rsp_type: data byte or line summary
//
// One character per cycle sustained while rsp_stall is low; a character is written
// into the queue, then the parser loads its result into the output register. Reset
// is synchronous: it empties the four-entry queue and restarts the parser.
// req_stall rises only when the queue is full; the queue fills while rsp_stall
// holds the output register.
module timestamped_hex_record_parser_top #(
   parameter int MAX_DATA_BYTES = 223
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  thrp_pkg::thrp_req_type req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output thrp_pkg::thrp_rsp_type rsp_payload
);
   import thrp_pkg::*;

   logic           push;
   logic           pop;
   thrp_tok_type   push_tok;
   thrp_tok_type   head_tok;
   thrp_qstat_type qstat;

   thrp_front u_front (
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .qstat       (qstat),
      .req_stall   (req_stall),
      .push        (push),
      .push_tok    (push_tok)
   );

   thrp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_tok (push_tok),
      .pop      (pop),
      .head_tok (head_tok),
      .qstat    (qstat)
   );

   thrp_back #(
      .MAX_DATA_BYTES (MAX_DATA_BYTES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_tok    (head_tok),
      .qstat       (qstat),
      .pop         (pop),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
   import thrp_pkg::*;

   localparam int MAX_PAIRS   = 223;
   localparam int STIM_CHARS  = 1080;
   localparam int IDLE_LIMIT  = 1000;
   localparam int DRAIN_TICKS = 10;

   typedef enum int {
      FAULT_NONE,
      FAULT_DEC_CHAR,
      FAULT_EARLY_STAR,
      FAULT_SRC_DIGIT,
      FAULT_ODD_DIGITS,
      FAULT_DATA_DIGIT,
      FAULT_TRUNCATE,
      FAULT_CK_DIGIT,
      FAULT_CK_VALUE
   } fault_type;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_valid   = 1'b0;
   logic         req_stall;
   thrp_req_type req_payload = '0;
   logic         rsp_valid;
   logic         rsp_stall   = 1'b0;
   thrp_rsp_type rsp_payload;

   timestamped_hex_record_parser_top #(.MAX_DATA_BYTES(MAX_PAIRS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   always #5 clock = ~clock;

   thrp_req_type line_chars[$];
   thrp_rsp_type awaited_results[$];

   int mismatches   = 0;
   int results_seen = 0;
   int idle_cycles  = 0;
   bit stuck        = 1'b0;
   int send_gap     = 0;
   int take_hold    = 0;
   bit send_calm    = 1'b0;
   bit take_calm    = 1'b0;

   // line builder: running checksum of what has been queued
   logic [7:0] gen_xor  = '0;
   bit         gen_open = 1'b0;

   // parser state as the block should hold it
   thrp_phase_type parse_phase = PH_AT;
   logic [31:0]    time_acc    = '0;
   logic [31:0]    group_acc   = '0;
   logic [7:0]     src_addr    = '0;
   logic [7:0]     run_xor     = '0;
   logic [3:0]     hi_nib      = '0;
   logic           half_pair   = 1'b0;
   logic [7:0]     pair_cnt    = '0;
   logic [7:0]     ck_seen     = '0;
   thrp_err_type   errs        = '0;
   logic           xor_closed  = 1'b0;

   // bit 4 set for a hex digit of either case, low nibble its value
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [7:0] v;
      v = '0;
      if (c >= "0" && c <= "9") v = c - "0";
      else if (c >= "A" && c <= "F") v = c - "A" + 8'd10;
      else if (c >= "a" && c <= "f") v = c - "a" + 8'd10;
      else return 5'd0;
      return {1'b1, v[3:0]};
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) return CHAR_ZERO + nib;
      return ($urandom_range(0, 1) ? "a" : "A") + nib - 8'd10;
   endfunction

   function automatic logic [7:0] non_hex();
      logic [7:0] c;
      logic [4:0] hx;
      do begin
         c  = 8'($urandom_range(1, 255));
         hx = hex_digit(c);
      end while (hx[4] || c == CHAR_STAR || c == CHAR_COMMA);
      return c;
   endfunction

   function automatic int idle_len(input bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic thrp_status_type line_result();
      if (errs.no_at) return ST_NO_AT;
      if (parse_phase >= PH_TIME && parse_phase <= PH_SEP) return ST_TRUNCATED;
      if (errs.bad_src) return ST_BAD_SRC;
      if (parse_phase == PH_DATA && half_pair) return ST_ODD_LEN;
      if (errs.too_long) return ST_TOO_LONG;
      if (errs.bad_data) return ST_BAD_DATA;
      if (parse_phase == PH_DATA || parse_phase == PH_CK_HI || parse_phase == PH_CK_LO)
         return ST_TRUNCATED;
      if (errs.bad_ck) return ST_BAD_CK;
      if (ck_seen != run_xor) return ST_MISMATCH;
      return ST_OK;
   endfunction

   task automatic clear_parser();
      parse_phase = PH_AT;
      time_acc    = '0;
      group_acc   = '0;
      src_addr    = '0;
      run_xor     = '0;
      hi_nib      = '0;
      half_pair   = 1'b0;
      pair_cnt    = '0;
      ck_seen     = '0;
      errs        = '0;
      xor_closed  = 1'b0;
   endtask

   task automatic parse_char(input thrp_req_type rq);
      logic [7:0]   c;
      logic [4:0]   hx;
      logic [3:0]   nib;
      thrp_rsp_type r;
      c  = rq.char_code;
      hx = hex_digit(c);
      nib = hx[4] ? hx[3:0] : 4'h0;
      r  = '0;
      r.timestamp      = time_acc;
      r.group_number   = group_acc;
      r.source_address = src_addr;
      r.status         = ST_OK;
      if (rq.line_end || c == CHAR_NUL) begin
         if (parse_phase == PH_AT) errs.no_at = 1'b1;
         r.kind           = KIND_SUMMARY;
         r.payload_length = pair_cnt;
         r.status         = line_result();
         awaited_results.push_back(r);
         clear_parser();
      end else begin
         if (parse_phase != PH_AT && parse_phase != PH_SKIP && !xor_closed) begin
            if (c == CHAR_STAR) xor_closed = 1'b1;
            else run_xor = run_xor ^ c;
         end
         case (parse_phase)
            PH_AT: begin
               if (c == CHAR_AT) begin
                  parse_phase = PH_TIME;
               end else begin
                  errs.no_at  = 1'b1;
                  parse_phase = PH_SKIP;
               end
            end
            PH_TIME: begin
               if (c == CHAR_COMMA) parse_phase = PH_GROUP;
               else time_acc = time_acc * 32'd10 + {24'd0, c} - {24'd0, CHAR_ZERO};
            end
            PH_GROUP: begin
               if (c == CHAR_COMMA) parse_phase = PH_SRC_HI;
               else group_acc = group_acc * 32'd10 + {24'd0, c} - {24'd0, CHAR_ZERO};
            end
            PH_SRC_HI, PH_SRC_LO: begin
               if (!hx[4]) errs.bad_src = 1'b1;
               src_addr    = {src_addr[3:0], nib};
               parse_phase = (parse_phase == PH_SRC_HI) ? PH_SRC_LO : PH_SEP;
            end
            PH_SEP: parse_phase = PH_DATA;
            PH_DATA: begin
               if (c == CHAR_STAR) begin
                  parse_phase = PH_CK_HI;
               end else begin
                  if (!hx[4]) errs.bad_data = 1'b1;
                  if (!half_pair) begin
                     hi_nib    = nib;
                     half_pair = 1'b1;
                  end else begin
                     half_pair = 1'b0;
                     if (pair_cnt >= 8'(MAX_PAIRS)) begin
                        errs.too_long = 1'b1;
                     end else begin
                        if (!errs.bad_data) begin
                           r.kind       = KIND_DATA;
                           r.data_byte  = {hi_nib, nib};
                           r.byte_index = pair_cnt;
                           awaited_results.push_back(r);
                        end
                        pair_cnt++;
                     end
                  end
               end
            end
            PH_CK_HI, PH_CK_LO: begin
               if (!hx[4]) errs.bad_ck = 1'b1;
               ck_seen     = {ck_seen[3:0], nib};
               parse_phase = (parse_phase == PH_CK_HI) ? PH_CK_LO : PH_TAIL;
            end
            default: ;
         endcase
      end
   endtask

   task automatic report(input string msg);
      // keep the log short on a badly broken build
      if (mismatches < 100) $display("mismatch: %s", msg);
      mismatches++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report($sformatf("result %0d %s: got %0h, want %0h", results_seen, name, got, want));
   endtask

   task automatic check_result(input thrp_rsp_type got);
      thrp_rsp_type want;
      if (awaited_results.size() == 0) begin
         report($sformatf("result %0d arrived with nothing awaited: %h", results_seen, got));
      end else begin
         want = awaited_results.pop_front();
         compare_field("kind", 32'(got.kind), 32'(want.kind));
         compare_field("data_byte", 32'(got.data_byte), 32'(want.data_byte));
         compare_field("byte_index", 32'(got.byte_index), 32'(want.byte_index));
         compare_field("timestamp", got.timestamp, want.timestamp);
         compare_field("group_number", got.group_number, want.group_number);
         compare_field("source_address", 32'(got.source_address),
                       32'(want.source_address));
         compare_field("payload_length", 32'(got.payload_length),
                       32'(want.payload_length));
         compare_field("status", 32'(got.status), 32'(want.status));
      end
      results_seen++;
   endtask

   task automatic put_char(input logic [7:0] c);
      line_chars.push_back({c, 1'b0});
      if (gen_open) begin
         if (c == CHAR_STAR) gen_open = 1'b0;
         else gen_xor = gen_xor ^ c;
      end
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) put_char(s[i]);
   endtask

   task automatic put_hex(input logic [7:0] v);
      put_char(hex_char(v[7:4]));
      put_char(hex_char(v[3:0]));
   endtask

   task automatic start_line();
      gen_open = 1'b0;
      put_char(CHAR_AT);
      gen_xor  = '0;
      gen_open = 1'b1;
   endtask

   task automatic end_line(input bit by_nul);
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      if (by_nul) line_chars.push_back({CHAR_NUL, 1'b0});
      else line_chars.push_back({c, 1'b1});
   endtask

   task automatic put_noise();
      int         n;
      logic [7:0] c;
      n = $urandom_range(0, 15);
      if ($urandom_range(0, 1)) start_line();
      for (int i = 0; i < n; i++) begin
         c = 8'($urandom_range(0, 255));
         line_chars.push_back({c, ($urandom_range(0, 7) == 0) ? 1'b1 : 1'b0});
      end
      end_line($urandom_range(0, 1) == 1);
   endtask

   task automatic put_record(input int n_pairs, input fault_type fault);
      int         n;
      int         spot;
      logic [7:0] ck;
      start_line();
      n = $urandom_range(0, 12);
      for (int i = 0; i < n; i++) put_char(CHAR_ZERO + 8'($urandom_range(0, 9)));
      if (fault == FAULT_DEC_CHAR) put_char(non_hex());
      put_char(CHAR_COMMA);
      n = $urandom_range(0, 12);
      spot = $urandom_range(0, n);
      for (int i = 0; i <= n; i++) begin
         if (fault == FAULT_EARLY_STAR && i == spot) put_char(CHAR_STAR);
         if (i < n) put_char(CHAR_ZERO + 8'($urandom_range(0, 9)));
      end
      put_char(CHAR_COMMA);
      spot = $urandom_range(0, 1);
      for (int d = 0; d < 2; d++) begin
         if (fault == FAULT_SRC_DIGIT && d == spot) put_char(non_hex());
         else put_char(hex_char(4'($urandom_range(0, 15))));
      end
      put_char(8'($urandom_range(1, 255)));
      spot = $urandom_range(0, 2 * n_pairs);
      for (int d = 0; d < 2 * n_pairs + ((fault == FAULT_ODD_DIGITS) ? 1 : 0); d++) begin
         if (fault == FAULT_DATA_DIGIT && d == spot) put_char(non_hex());
         else put_char(hex_char(4'($urandom_range(0, 15))));
      end
      if (fault == FAULT_TRUNCATE) begin
         n = $urandom_range(0, 2);
         if (n > 0) put_char(CHAR_STAR);
         if (n > 1) put_char(hex_char(4'($urandom_range(0, 15))));
         end_line($urandom_range(0, 1) == 1);
      end else begin
         put_char(CHAR_STAR);
         ck = gen_xor;
         if (fault == FAULT_CK_VALUE) ck = ck ^ 8'($urandom_range(1, 255));
         spot = $urandom_range(0, 1);
         for (int d = 0; d < 2; d++) begin
            if (fault == FAULT_CK_DIGIT && d == spot) put_char(non_hex());
            else put_char(hex_char((d == 0) ? ck[7:4] : ck[3:0]));
         end
         if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) put_char(8'($urandom_range(1, 255)));
         end
         end_line($urandom_range(0, 3) == 0);
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (line_chars.size() > 0) begin
            req_payload <= line_chars.pop_front();
            req_valid   <= 1'b1;
            if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
            send_gap = idle_len(send_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // predict on each accepted request, then check each accepted result
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         clear_parser();
         idle_cycles = 0;
      end else begin
         if (req_valid && !req_stall) parse_char(req_payload);
         if (rsp_valid && !rsp_stall) check_result(rsp_payload);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) stuck = 1'b1;
         end
         if (take_hold > 0) begin
            take_hold--;
            rsp_stall <= 1'b1;
         end else begin
            if ($urandom_range(0, 63) == 0) take_calm = !take_calm;
            take_hold = idle_len(take_calm);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int        r;
      fault_type fault;

      // line end flag alone, then a NUL alone, then a line without the at sign
      end_line(1'b0);
      end_line(1'b1);
      put_char("Z");
      end_line(1'b0);
      // stop inside the timestamp
      start_line();
      put_text("42");
      end_line(1'b0);
      // a clean line with mixed-case hex
      start_line();
      put_text("7,9,fF 00Ffa5");
      put_char(CHAR_STAR);
      put_hex(gen_xor);
      end_line(1'b1);
      // bad source digit, star closing the data, no checksum
      start_line();
      put_text(",,G0|*");
      end_line(1'b0);

      // one pair over the payload limit
      put_record(MAX_PAIRS + 1, FAULT_NONE);

      while (line_chars.size() < STIM_CHARS) begin
         r = $urandom_range(0, 99);
         fault = $urandom_range(0, 1) ? FAULT_NONE
                 : fault_type'($urandom_range(FAULT_DEC_CHAR, FAULT_CK_VALUE));
         if (r < 12) put_noise();
         else if (r < 97) put_record($urandom_range(0, 8), fault);
         else put_record($urandom_range(9, 40), fault);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (!stuck && (line_chars.size() > 0 || req_valid || awaited_results.size() > 0))
         @(posedge clock);
      if (!stuck) repeat (DRAIN_TICKS) @(posedge clock);

      if (stuck) begin
         $display("TB_ERROR");
      end else if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
